### hw/rtl/sgns_pkg.sv
// Package for the skip-gram negative-sampling update engine.
// It holds the channel payload types, the operation and register codes and the sigmoid table.
// It has no dependencies.
`default_nettype none

package sgns_pkg;

   typedef struct packed {
      logic [1:0]         op;
      logic [9:0]         target_word;
      logic [9:0]         context_word;
      logic [9:0]         negative_word;
      logic [5:0]         element_index;
      logic signed [15:0] write_value;
   } req_type;

   typedef struct packed {
      logic signed [15:0] read_value;
      logic [15:0]        positive_score;
      logic               saturated;
   } rsp_type;

   localparam logic [1:0] OP_WRITE = 2'd0;
   localparam logic [1:0] OP_READ  = 2'd1;
   localparam logic [1:0] OP_TRAIN = 2'd2;

   // Word index of the learning rate register on the configuration port.
   localparam logic CSR_LEARNING_RATE = 1'b0;
   localparam logic [15:0] LEARNING_RATE_RESET = 16'd819;

   // Sigmoid at k/2 in unsigned Q0.16; the last breakpoint repeats so that
   // the segment past the top of the range has zero slope.
   function automatic logic [15:0] sig_tab(input logic [4:0] k);
      logic [15:0] v;
      case (k)
         5'd0:    v = 16'd32768;
         5'd1:    v = 16'd40793;
         5'd2:    v = 16'd47910;
         5'd3:    v = 16'd53580;
         5'd4:    v = 16'd57724;
         5'd5:    v = 16'd60564;
         5'd6:    v = 16'd62428;
         5'd7:    v = 16'd63615;
         5'd8:    v = 16'd64357;
         5'd9:    v = 16'd64816;
         5'd10:   v = 16'd65097;
         5'd11:   v = 16'd65269;
         5'd12:   v = 16'd65374;
         5'd13:   v = 16'd65438;
         5'd14:   v = 16'd65476;
         5'd15:   v = 16'd65500;
         default: v = 16'd65514;
      endcase
      return v;
   endfunction

endpackage

`default_nettype wire

### hw/rtl/sgns_ram.sv
// Generic single-port RAM with a registered read, used for the embedding table.
// It has no dependencies.
`default_nettype none

module sgns_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 65536
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wdata,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

### hw/rtl/sgns_mul.sv
// Shared signed multiplier with a registered product.
// It serves the dot products, the sigmoid interpolation, the gradients and the updates.
`default_nettype none

module sgns_mul (
   input  wire logic               clock,
   input  wire logic signed [18:0] a,
   input  wire logic signed [16:0] b,
   output logic signed      [35:0] prod
);

   logic signed [35:0] prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= 36'(a * b);
   end

   assign prod = prod_ff;

endmodule

`default_nettype wire

### hw/rtl/skipgram_negative_sample_update.sv
// Top level of the skip-gram negative-sampling update engine.
// Depends on sgns_pkg, sgns_ram (embedding table) and sgns_mul (shared multiplier).
`default_nettype none

// Channel   Signals                                  Direction  Transfer when
// req       req_valid, req_ready, req_data           in         req_valid and req_ready
// rsp       rsp_valid, rsp_ready, rsp_data           out        rsp_valid and rsp_ready
// csr       psel, penable, pwrite, paddr, pwdata,    in/out     psel, penable, pwrite high
//           prdata, pready (always high)
//
// An element write goes from its transfer straight to the result step, and an element
// read passes the read step first. A train item is paced by the single table port and
// the one shared multiplier: per element, the two dot products read the three rows and
// multiply; the sigmoid and gradient steps run for the positive, then the negative score;
// per element, the read-modify-write updates all three rows.
// Reset is synchronous; it clears the sequencer and the result valid and restores the
// learning rate. The table itself is not cleared.
// A result that waits on rsp_ready holds the next item in its last step until it drains.

module skipgram_negative_sample_update #(
   parameter int NUM_WORDS = 1024,
   parameter int DIM       = 64
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_ready,
   input  wire sgns_pkg::req_type req_data,
   output logic                 rsp_valid,
   input  wire logic            rsp_ready,
   output sgns_pkg::rsp_type    rsp_data,
   input  wire logic            psel,
   input  wire logic            penable,
   input  wire logic            pwrite,
   input  wire logic [2:0]      paddr,
   input  wire logic [31:0]     pwdata,
   output logic      [31:0]     prdata,
   output logic                 pready
);

   import sgns_pkg::*;

   localparam int DEPTH = NUM_WORDS * DIM;
   localparam int AW    = $clog2(DEPTH);
   localparam int IW    = $clog2(DIM + 1);
   localparam int ACC_W = 33 + $clog2(DIM);
   localparam int SUM_W = 37;
   localparam logic signed [ACC_W-1:0] LIM_HI = ACC_W'(64'sd134217728);
   localparam logic signed [ACC_W-1:0] LIM_LO = -LIM_HI;

   typedef enum logic [4:0] {
      ST_IDLE, ST_RD,
      ST_P1_RW, ST_P1_RC, ST_P1_RN, ST_P1_MC, ST_P1_MN, ST_P1_ACC,
      ST_SG_MUL, ST_SG_FIN, ST_GR_MUL, ST_GR_FIN,
      ST_P2_RW, ST_P2_RC, ST_P2_RN, ST_P2_MC, ST_P2_MN, ST_P2_WW, ST_P2_WC, ST_P2_WN,
      ST_DONE
   } state_type;

   state_type state_ff;

   logic [15:0]              lr_ff;
   logic [9:0]               w_word_ff, c_word_ff, n_word_ff;
   logic [IW-1:0]            idx_ff;
   logic                     inr_ff;
   logic signed [15:0]       rdv_ff;
   logic signed [15:0]       w_ff, c_ff, n_ff;
   logic signed [ACC_W-1:0]  acc_pos_ff, acc_neg_ff;
   logic                     neg_ff;
   logic [15:0]              base_ff;
   logic                     sneg_ff;
   logic [15:0]              sp_ff, sn_ff;
   logic signed [18:0]       gp_ff, gn_ff;
   logic signed [SUM_W-1:0]  sum_ff;
   logic                     clip_ff;
   logic                     rsp_valid_ff;
   rsp_type                  rsp_data_ff;

   // Table port and multiplier operands.
   logic                     ram_we;
   logic [9:0]               row_sel;
   logic [31:0]              col_sel;
   logic [AW-1:0]            ram_addr;
   logic [15:0]              ram_wdata;
   logic [15:0]              ram_q;
   logic signed [18:0]       mul_a;
   logic signed [16:0]       mul_b;
   logic signed [35:0]       prod;

   // Request decode.
   logic                     req_fire;
   logic                     req_row_ok, req_col_ok, req_train_ok;

   // Sigmoid front end.
   logic signed [ACC_W-1:0]  acc_sel;
   logic signed [15:0]       s_val;
   logic signed [16:0]       s_ext;
   logic [16:0]              m_val;
   logic [4:0]               seg;
   logic [10:0]              frac;
   logic signed [16:0]       slope;
   logic [16:0]              y_val;
   logic [15:0]              sig_val;
   logic signed [18:0]       grad;

   // Update path.
   logic signed [SUM_W-1:0]  term_sum;
   logic signed [20:0]       term_rnd;
   logic signed [15:0]       old_sel;
   logic signed [21:0]       new_raw;
   logic signed [15:0]       new_sat;
   logic                     new_clip;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;

   assign req_row_ok   = 32'(req_data.target_word) < NUM_WORDS;
   assign req_col_ok   = 32'(req_data.element_index) < DIM;
   assign req_train_ok = req_row_ok && (32'(req_data.context_word) < NUM_WORDS)
                         && (32'(req_data.negative_word) < NUM_WORDS);

   // Score input: floor(dot / 2^12) clamped to Q4.12, then |s| split into
   // a segment number and a fraction for the interpolation.
   assign acc_sel = neg_ff ? acc_neg_ff : acc_pos_ff;
   always_comb begin
      if (acc_sel >= LIM_HI) begin
         s_val = 16'sh7FFF;
      end else if (acc_sel < LIM_LO) begin
         s_val = -16'sh8000;
      end else begin
         s_val = acc_sel[27:12];
      end
   end
   assign s_ext = 17'(s_val);
   assign m_val = s_val[15] ? 17'(-s_ext) : 17'(s_ext);
   assign seg   = 5'(m_val >> 11);
   assign frac  = m_val[10:0];
   assign slope = $signed({1'b0, sig_tab(seg + 5'd1)}) - $signed({1'b0, sig_tab(seg)});

   assign y_val   = {1'b0, base_ff} + 17'(prod >>> 11);
   assign sig_val = sneg_ff ? 16'(17'd65536 - y_val) : y_val[15:0];
   assign grad    = $signed({1'b0, prod[32:15]});

   // One element of an updated row: round the update term, add, saturate.
   assign term_sum = (state_ff == ST_P2_WW) ? (sum_ff + SUM_W'(prod)) : SUM_W'(prod);
   assign term_rnd = 21'((term_sum + SUM_W'(32768)) >>> 16);
   always_comb begin
      case (state_ff)
         ST_P2_WW: old_sel = w_ff;
         ST_P2_WC: old_sel = c_ff;
         default:  old_sel = n_ff;
      endcase
   end
   assign new_raw = 22'(old_sel) + 22'(term_rnd);
   always_comb begin
      new_clip = 1'b1;
      if (new_raw > 22'sd32767) begin
         new_sat = 16'sh7FFF;
      end else if (new_raw < -22'sd32768) begin
         new_sat = -16'sh8000;
      end else begin
         new_sat  = new_raw[15:0];
         new_clip = 1'b0;
      end
   end

   // Table port and multiplier operand selection.
   always_comb begin
      ram_we    = 1'b0;
      row_sel   = w_word_ff;
      col_sel   = 32'(idx_ff);
      ram_wdata = new_sat;
      mul_a     = '0;
      mul_b     = '0;
      unique case (state_ff)
         ST_IDLE: begin
            row_sel   = req_data.target_word;
            col_sel   = 32'(req_data.element_index);
            ram_wdata = req_data.write_value;
            ram_we    = req_fire && (req_data.op == OP_WRITE) && req_row_ok && req_col_ok;
         end
         ST_P1_RC, ST_P2_RC: row_sel = c_word_ff;
         ST_P1_RN, ST_P2_RN: row_sel = n_word_ff;
         ST_P1_MC: begin
            mul_a = 19'(w_ff);
            mul_b = 17'(c_ff);
         end
         ST_P1_MN: begin
            mul_a = 19'(w_ff);
            mul_b = 17'(n_ff);
         end
         ST_SG_MUL: begin
            mul_a = 19'(slope);
            mul_b = $signed({6'b0, frac});
         end
         ST_GR_MUL: begin
            mul_a = neg_ff ? $signed({3'b0, sn_ff}) : $signed(19'(17'd65536 - {1'b0, sp_ff}));
            mul_b = $signed({1'b0, lr_ff});
         end
         ST_P2_MC: begin
            mul_a = gp_ff;
            mul_b = 17'(c_ff);
         end
         ST_P2_MN: begin
            mul_a = gn_ff;
            mul_b = 17'(n_ff);
         end
         ST_P2_WW: begin
            ram_we = 1'b1;
            mul_a  = gp_ff;
            mul_b  = 17'(w_ff);
         end
         ST_P2_WC: begin
            ram_we  = 1'b1;
            row_sel = c_word_ff;
            mul_a   = gn_ff;
            mul_b   = 17'(w_ff);
         end
         ST_P2_WN: begin
            ram_we  = 1'b1;
            row_sel = n_word_ff;
         end
         default: ;
      endcase
   end

   assign ram_addr = AW'(32'(row_sel) * DIM + col_sel);

   sgns_ram #(
      .WIDTH (16),
      .DEPTH (DEPTH)
   ) u_table (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_q)
   );

   sgns_mul u_mul (
      .clock (clock),
      .a     (mul_a),
      .b     (mul_b),
      .prod  (prod)
   );

   // Sequencer.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         // In the final step the result register is refilled instead of cleared.
         if (rsp_valid_ff && rsp_ready && (state_ff != ST_DONE)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_fire) begin
                  w_word_ff  <= req_data.target_word;
                  c_word_ff  <= req_data.context_word;
                  n_word_ff  <= req_data.negative_word;
                  inr_ff     <= req_row_ok && req_col_ok;
                  rdv_ff     <= '0;
                  sp_ff      <= '0;
                  clip_ff    <= 1'b0;
                  idx_ff     <= '0;
                  acc_pos_ff <= '0;
                  acc_neg_ff <= '0;
                  neg_ff     <= 1'b0;
                  if (req_data.op == OP_READ) begin
                     state_ff <= ST_RD;
                  end else if (req_data.op == OP_TRAIN && req_train_ok) begin
                     state_ff <= ST_P1_RW;
                  end else begin
                     state_ff <= ST_DONE;
                  end
               end
            end
            ST_RD: begin
               if (inr_ff) begin
                  rdv_ff <= ram_q;
               end
               state_ff <= ST_DONE;
            end
            ST_P1_RW: state_ff <= ST_P1_RC;
            ST_P1_RC: begin
               w_ff     <= ram_q;
               state_ff <= ST_P1_RN;
            end
            ST_P1_RN: begin
               c_ff     <= ram_q;
               state_ff <= ST_P1_MC;
            end
            ST_P1_MC: begin
               n_ff     <= ram_q;
               state_ff <= ST_P1_MN;
            end
            ST_P1_MN: begin
               acc_pos_ff <= acc_pos_ff + ACC_W'(prod);
               idx_ff     <= idx_ff + 1'b1;
               state_ff   <= ST_P1_ACC;
            end
            ST_P1_ACC: begin
               acc_neg_ff <= acc_neg_ff + ACC_W'(prod);
               if (idx_ff == IW'(DIM)) begin
                  idx_ff   <= '0;
                  state_ff <= ST_SG_MUL;
               end else begin
                  state_ff <= ST_P1_RC;
               end
            end
            ST_SG_MUL: begin
               base_ff  <= sig_tab(seg);
               sneg_ff  <= s_val[15];
               state_ff <= ST_SG_FIN;
            end
            ST_SG_FIN: begin
               if (neg_ff) begin
                  sn_ff <= sig_val;
               end else begin
                  sp_ff <= sig_val;
               end
               state_ff <= ST_GR_MUL;
            end
            ST_GR_MUL: state_ff <= ST_GR_FIN;
            ST_GR_FIN: begin
               if (neg_ff) begin
                  gn_ff    <= -grad;
                  state_ff <= ST_P2_RW;
               end else begin
                  gp_ff    <= grad;
                  neg_ff   <= 1'b1;
                  state_ff <= ST_SG_MUL;
               end
            end
            ST_P2_RW: state_ff <= ST_P2_RC;
            ST_P2_RC: begin
               w_ff     <= ram_q;
               state_ff <= ST_P2_RN;
            end
            ST_P2_RN: begin
               c_ff     <= ram_q;
               state_ff <= ST_P2_MC;
            end
            ST_P2_MC: begin
               n_ff     <= ram_q;
               state_ff <= ST_P2_MN;
            end
            ST_P2_MN: begin
               sum_ff   <= SUM_W'(prod);
               state_ff <= ST_P2_WW;
            end
            ST_P2_WW: begin
               clip_ff  <= clip_ff | new_clip;
               state_ff <= ST_P2_WC;
            end
            ST_P2_WC: begin
               clip_ff  <= clip_ff | new_clip;
               state_ff <= ST_P2_WN;
            end
            ST_P2_WN: begin
               clip_ff <= clip_ff | new_clip;
               idx_ff  <= idx_ff + 1'b1;
               if (idx_ff == IW'(DIM - 1)) begin
                  state_ff <= ST_DONE;
               end else begin
                  state_ff <= ST_P2_RW;
               end
            end
            ST_DONE: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_data_ff.read_value     <= rdv_ff;
                  rsp_data_ff.positive_score <= sp_ff;
                  rsp_data_ff.saturated      <= clip_ff;
                  rsp_valid_ff               <= 1'b1;
                  state_ff                   <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Configuration register.
   always_ff @(posedge clock) begin
      if (reset) begin
         lr_ff <= LEARNING_RATE_RESET;
      end else if (psel && penable && pwrite && (paddr[2] == CSR_LEARNING_RATE)) begin
         lr_ff <= pwdata[15:0];
      end
   end

   assign prdata = (paddr[2] == CSR_LEARNING_RATE) ? {16'b0, lr_ff} : 32'b0;
   assign pready = 1'b1;

endmodule

`default_nettype wire

### hw/rtl/sgns_chk.sv
// Port-level checker for the skip-gram negative-sampling update engine.
// Depends on sgns_pkg; bound to the top level at the end of this file.
`default_nettype none

module sgns_chk (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_ready,
   input wire sgns_pkg::req_type req_data,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready,
   input wire sgns_pkg::rsp_type rsp_data
);

   import sgns_pkg::*;

   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_data))
      else $error("request changed before its transfer");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped before its transfer");

   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("block ready again right after taking an item");

   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_train_only: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.saturated || rsp_data.read_value != 16'sd0)
      |-> ((rsp_data.read_value == 16'sd0) != (rsp_data.positive_score == 16'd0)))
      else $error("read and train result fields mixed");

endmodule

bind skipgram_negative_sample_update sgns_chk u_chk (.*);

`default_nettype wire

### sim/tb.sv
// Testbench for the skip-gram negative-sampling update engine.
// It drives element writes, reads, train items and op 3 items through the request channel and
// checks every response against a built-in predictor. It depends on sgns_pkg and the RTL top.
`default_nettype none

module tb;
   import sgns_pkg::*;

   localparam int VOCA = 1024;
   localparam int DIMS = 64;
   // Cycles a stalled channel may go without any transfer before the run is declared hung.
   // A train item keeps the block busy, and the receiver may stall for a long stretch on top.
   localparam int HANG_LIMIT = 20000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
   logic [2:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic pready;

   skipgram_negative_sample_update #(.NUM_WORDS(VOCA), .DIM(DIMS)) dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // The predictor keeps its own copy of the table and the learning rate. It is updated when
   // a request transfer is seen, so the expected response is ready before it comes back.
   logic signed [15:0] shadow_table [0:VOCA*DIMS-1];
   logic [15:0]        shadow_rate;

   req_type pending_reqs[$];
   rsp_type expected_rsps[$];

   int  sender_idle_pct = 0;
   int  receiver_idle_pct = 0;
   int  error_count = 0;
   int  rsp_count = 0;
   int  train_count = 0;
   int  sat_count = 0;
   int  stall_cycles = 0;
   bit  timed_out = 1'b0;

   // Captured at the rising edge so the driver knows whether its item was taken.
   bit req_ready_seen = 1'b0;

   function automatic void add_req(input req_type r);
      pending_reqs.insert(pending_reqs.size(), r);
   endfunction

   // Piecewise-linear sigmoid over a Q8.24 dot product, returning Q0.16.
   function automatic logic [15:0] score_sigmoid(input longint dotp);
      longint s, m, seg, f, lo, hi;
      if (dotp >= (64'sd8 <<< 24)) s = 32767;
      else if (dotp < -(64'sd8 <<< 24)) s = -32768;
      else s = ((dotp + (64'sd8 <<< 24)) >>> 12) - 32768;
      m = (s < 0) ? -s : s;
      seg = m >> 11;
      if (seg > 16) seg = 16;
      f = m & 2047;
      lo = sig_tab(5'(seg));
      hi = sig_tab(5'(seg + 1));
      m = lo + ((hi - lo) * f) / 2048;
      return (s >= 0) ? 16'(m) : 16'(65536 - m);
   endfunction

   function automatic longint round_q16(input longint v);
      return (v + 32768) >>> 16;
   endfunction

   function automatic logic signed [15:0] clip16(input longint v, inout bit clipped);
      if (v > 32767) begin
         clipped = 1'b1;
         return 16'sh7fff;
      end
      if (v < -32768) begin
         clipped = 1'b1;
         return 16'sh8000;
      end
      return 16'(v);
   endfunction

   function automatic rsp_type predict_response(input req_type r);
      rsp_type res;
      longint w [DIMS], c [DIMS], n [DIMS];
      longint dot_pos, dot_neg, gp, gn;
      logic [15:0] sp, sn;
      logic signed [15:0] nw [DIMS], nc [DIMS], nn [DIMS];
      bit clipped;
      int bw, bc, bn;
      res = '0;
      clipped = 1'b0;
      bw = int'(r.target_word) * DIMS;
      bc = int'(r.context_word) * DIMS;
      bn = int'(r.negative_word) * DIMS;
      case (r.op)
         OP_WRITE: shadow_table[bw + r.element_index] = r.write_value;
         OP_READ: res.read_value = shadow_table[bw + r.element_index];
         OP_TRAIN: begin
            dot_pos = 0;
            dot_neg = 0;
            for (int i = 0; i < DIMS; i++) begin
               w[i] = shadow_table[bw + i];
               c[i] = shadow_table[bc + i];
               n[i] = shadow_table[bn + i];
               dot_pos += w[i] * c[i];
               dot_neg += w[i] * n[i];
            end
            sp = score_sigmoid(dot_pos);
            sn = score_sigmoid(dot_neg);
            gp = (longint'(shadow_rate) * (65536 - longint'(sp))) / 32768;
            gn = -((longint'(shadow_rate) * longint'(sn)) / 32768);
            for (int i = 0; i < DIMS; i++) begin
               nw[i] = clip16(w[i] + round_q16(gp * c[i] + gn * n[i]), clipped);
               nc[i] = clip16(c[i] + round_q16(gp * w[i]), clipped);
               nn[i] = clip16(n[i] + round_q16(gn * w[i]), clipped);
            end
            // Coinciding rows: write order w, c, n so the later row wins.
            for (int i = 0; i < DIMS; i++) shadow_table[bw + i] = nw[i];
            for (int i = 0; i < DIMS; i++) shadow_table[bc + i] = nc[i];
            for (int i = 0; i < DIMS; i++) shadow_table[bn + i] = nn[i];
            res.positive_score = sp;
            res.saturated = clipped;
         end
         default: ;
      endcase
      return res;
   endfunction

   // Driver: presents the next pending item at the falling edge and holds it until the
   // transfer. A new item is only raised after the previous transfer, so valid is assigned
   // once per step.
   always @(negedge clock) begin
      if (!reset) begin
         if (!req_valid || req_ready_seen) begin
            if (pending_reqs.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
               req_data <= pending_reqs.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
         rsp_ready <= ($urandom_range(99) >= receiver_idle_pct);
      end
   end

   // Monitor: samples both channels at the rising edge.
   always @(posedge clock) begin
      if (reset) begin
         req_ready_seen <= 1'b0;
      end else begin
         req_ready_seen <= req_valid && req_ready;
         if (req_valid && req_ready) begin
            expected_rsps.insert(expected_rsps.size(), predict_response(req_data));
         end
         if (rsp_valid && rsp_ready) begin
            rsp_count++;
            if (expected_rsps.size() == 0) begin
               $display("%0t: unexpected response %h", $time, rsp_data);
               error_count++;
            end else begin
               rsp_type e;
               e = expected_rsps.pop_front();
               if (e.read_value !== rsp_data.read_value) begin
                  $display("%0t: read_value expected %0d actual %0d", $time,
                           e.read_value, rsp_data.read_value);
                  error_count++;
               end
               if (e.positive_score !== rsp_data.positive_score) begin
                  $display("%0t: positive_score expected %0d actual %0d", $time,
                           e.positive_score, rsp_data.positive_score);
                  error_count++;
               end
               if (e.saturated !== rsp_data.saturated) begin
                  $display("%0t: saturated expected %0d actual %0d", $time,
                           e.saturated, rsp_data.saturated);
                  error_count++;
               end
               if (e.saturated) sat_count++;
            end
         end
         // Watchdog: counts cycles with no transfer on either channel while work is waiting.
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)
             || (pending_reqs.size() == 0 && expected_rsps.size() == 0 && !req_valid)) begin
            stall_cycles <= 0;
         end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles + 1 >= HANG_LIMIT) timed_out <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (timed_out) begin
         $display("tb: failure");
         $finish;
      end
   end

   // Writes the learning rate through the configuration port: setup, then access.
   task automatic write_rate(input logic [15:0] rate);
      @(negedge clock);
      psel <= 1'b1;
      pwrite <= 1'b1;
      paddr <= 3'(CSR_LEARNING_RATE) << 2;
      pwdata <= {16'd0, rate};
      @(negedge clock);
      penable <= 1'b1;
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      shadow_rate = rate;
   endtask

   // Waits for the channel to drain and the block to settle so that a register write is safe.
   task automatic wait_idle();
      while (pending_reqs.size() > 0 || req_valid || expected_rsps.size() > 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   function automatic req_type make_access(input logic [1:0] op, input int row, input int elem,
                                           input logic [15:0] val);
      req_type r;
      r = '0;
      r.op = op;
      r.target_word = 10'(row);
      r.element_index = 6'(elem);
      r.write_value = val;
      // Unused index fields carry random bits so every bit toggles.
      r.context_word = 10'($urandom);
      r.negative_word = 10'($urandom);
      return r;
   endfunction

   // Loads a row through element writes with random content of a chosen magnitude.
   task automatic load_row(input int row, input int mag);
      for (int i = 0; i < DIMS; i++) begin
         int v;
         v = $urandom_range(2 * mag) - mag;
         add_req(make_access(OP_WRITE, row, i, 16'(v)));
      end
   endtask

   function automatic req_type make_train(input int w, input int c, input int n);
      req_type r;
      r = '0;
      r.op = OP_TRAIN;
      r.target_word = 10'(w);
      r.context_word = 10'(c);
      r.negative_word = 10'(n);
      r.element_index = 6'($urandom);
      r.write_value = 16'($urandom);
      return r;
   endfunction

   // Rows that have been loaded in full, so train and read items stay on written data.
   int loaded_rows[$];

   task automatic queue_phase(input int count);
      int issued;
      issued = 0;
      while (issued < count) begin
         int pick;
         pick = $urandom_range(99);
         if (pick < 8 || loaded_rows.size() < 3) begin
            int row;
            row = $urandom_range(VOCA - 1);
            load_row(row, ($urandom_range(3) == 0) ? 32767 : $urandom_range(1, 8000));
            loaded_rows.insert(loaded_rows.size(), row);
            issued += DIMS;
         end else if (pick < 45) begin
            int row;
            row = loaded_rows[$urandom_range(loaded_rows.size() - 1)];
            add_req(make_access(OP_READ, row, $urandom_range(DIMS - 1), 16'($urandom)));
            issued++;
         end else if (pick < 60) begin
            int row;
            row = loaded_rows[$urandom_range(loaded_rows.size() - 1)];
            add_req(make_access(OP_WRITE, row, $urandom_range(DIMS - 1), 16'($urandom)));
            issued++;
         end else if (pick < 65) begin
            req_type r;
            r = $bits(req_type)'({$urandom, $urandom});
            r.op = 2'd3;
            add_req(r);
            issued++;
         end else begin
            int w, c, n;
            w = loaded_rows[$urandom_range(loaded_rows.size() - 1)];
            c = ($urandom_range(9) == 0) ? w : loaded_rows[$urandom_range(loaded_rows.size() - 1)];
            n = ($urandom_range(9) == 0) ? c : loaded_rows[$urandom_range(loaded_rows.size() - 1)];
            add_req(make_train(w, c, n));
            train_count++;
            issued++;
         end
      end
   endtask

   initial begin
      shadow_rate = LEARNING_RATE_RESET;
      for (int i = 0; i < VOCA * DIMS; i++) begin
         shadow_table[i] = '0;
      end
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part: extreme rows and elements, extreme values, every op, and trains that
      // hit the reset rate, coinciding rows and full saturation.
      add_req(make_access(OP_WRITE, 0, 0, 16'sh7fff));
      add_req(make_access(OP_WRITE, VOCA - 1, DIMS - 1, 16'sh8000));
      add_req(make_access(OP_READ, 0, 0, 16'hffff));
      add_req(make_access(OP_READ, VOCA - 1, DIMS - 1, 16'h0));
      add_req(make_access(2'd3, VOCA - 1, DIMS - 1, 16'hffff));
      load_row(0, 32767);
      load_row(VOCA - 1, 32767);
      load_row(5, 100);
      loaded_rows = '{0, VOCA - 1, 5};
      add_req(make_train(0, VOCA - 1, 5));
      add_req(make_train(0, 0, 0));
      add_req(make_train(5, 5, VOCA - 1));
      train_count += 3;

      sender_idle_pct = 21;
      receiver_idle_pct = 88;
      wait_idle();
      write_rate(16'hffff);
      add_req(make_train(0, VOCA - 1, 5));
      add_req(make_train(VOCA - 1, 0, 0));
      train_count += 2;
      queue_phase(180);
      wait_idle();

      write_rate(16'd0);
      sender_idle_pct = 88;
      receiver_idle_pct = 21;
      queue_phase(90);
      wait_idle();

      write_rate(16'($urandom));
      sender_idle_pct = 0;
      receiver_idle_pct = 0;
      queue_phase(180);
      wait_idle();
      write_rate(LEARNING_RATE_RESET);
      queue_phase(40);
      wait_idle();

      $display("tb: %0d responses checked, %0d train steps (%0d clipped), learning rate swept",
               rsp_count, train_count, sat_count);
      $display("tb: over zero, reset, maximum and random settings under three idling patterns");
      if (error_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

`default_nettype wire

### skipgram_negative_sample_update.f
hw/rtl/sgns_pkg.sv
hw/rtl/sgns_ram.sv
hw/rtl/sgns_mul.sv
hw/rtl/skipgram_negative_sample_update.sv
hw/rtl/sgns_chk.sv
sim/tb.sv
